[hdl/tfn_pkg.sv]
// Shared widths and types for the triangle face normal pipeline.
package tfn_pkg;
  localparam int CoordBits     = 16;
  localparam int NormalFracBits = 14;
  localparam int NormalBits    = NormalFracBits + 2;
  localparam int MagBits       = 31;
  localparam int SumBits       = 64;
  localparam int RootBits      = 32;

  typedef struct packed {
    logic       neg_x;
    logic       neg_y;
    logic       neg_z;
    logic       degen;
  } tfn_flags_t;
endpackage

[hdl/tfn_cross.sv]
// Edge vectors, cross product and scaling of the magnitudes to 31 bits.
module tfn_cross
  import tfn_pkg::*;
#(
  parameter int COORD_BITS = CoordBits
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS-1:0] p1x, p1y, p1z, p2x, p2y, p2z, p3x, p3y, p3z,
  output logic                         out_vld,
  output logic [MagBits-1:0]           mx, my, mz,
  output tfn_flags_t                   flags
);
  localparam int EB = COORD_BITS + 1;
  localparam int PB = 2 * EB;
  localparam int CB = PB + 1;
  localparam int LB = $clog2(CB + 1);

  logic                 v1_r, v2_r, v3_r;
  logic signed [EB-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [PB-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [CB-1:0] cx, cy, cz;
  logic        [CB-1:0] ax_r, ay_r, az_r, orv;
  logic                 nx_r, ny_r, nz_r;
  logic        [LB-1:0] bl;
  logic        [MagBits-1:0] mx_r, my_r, mz_r;
  tfn_flags_t           fl_r;
  logic                 vo_r;

  always_ff @(posedge clk) begin
    e1x_r <= EB'(p2x) - EB'(p1x);
    e1y_r <= EB'(p2y) - EB'(p1y);
    e1z_r <= EB'(p2z) - EB'(p1z);
    e2x_r <= EB'(p3x) - EB'(p1x);
    e2y_r <= EB'(p3y) - EB'(p1y);
    e2z_r <= EB'(p3z) - EB'(p1z);
    pa_r <= e1y_r * e2z_r;
    pb_r <= e1z_r * e2y_r;
    pc_r <= e1z_r * e2x_r;
    pd_r <= e1x_r * e2z_r;
    pe_r <= e1x_r * e2y_r;
    pf_r <= e1y_r * e2x_r;
    nx_r <= cx[CB-1];
    ny_r <= cy[CB-1];
    nz_r <= cz[CB-1];
    ax_r <= cx[CB-1] ? CB'(-cx) : CB'(cx);
    ay_r <= cy[CB-1] ? CB'(-cy) : CB'(cy);
    az_r <= cz[CB-1] ? CB'(-cz) : CB'(cz);
    if (bl <= LB'(MagBits)) begin
      mx_r <= MagBits'(ax_r << (LB'(MagBits) - bl));
      my_r <= MagBits'(ay_r << (LB'(MagBits) - bl));
      mz_r <= MagBits'(az_r << (LB'(MagBits) - bl));
    end else begin
      mx_r <= MagBits'(ax_r >> (bl - LB'(MagBits)));
      my_r <= MagBits'(ay_r >> (bl - LB'(MagBits)));
      mz_r <= MagBits'(az_r >> (bl - LB'(MagBits)));
    end
    fl_r <= '{neg_x: nx_r, neg_y: ny_r, neg_z: nz_r, degen: (orv == '0)};
  end

  always_comb begin
    cx  = CB'(pa_r) - CB'(pb_r);
    cy  = CB'(pc_r) - CB'(pd_r);
    cz  = CB'(pe_r) - CB'(pf_r);
    orv = ax_r | ay_r | az_r;
    bl  = '0;
    for (int i = 0; i < CB; i++) begin
      if (orv[i]) bl = LB'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  assign out_vld = vo_r;
  assign mx = mx_r;
  assign my = my_r;
  assign mz = mz_r;
  assign flags = fl_r;
endmodule

[hdl/tfn_sqrt.sv]
// Sum of squares and pipelined integer square root, one result bit a stage.
module tfn_sqrt
  import tfn_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [MagBits-1:0] mx, my, mz,
  input  tfn_flags_t         in_flags,
  output logic               out_vld,
  output logic [MagBits-1:0] ox, oy, oz,
  output logic [RootBits-1:0] root,
  output tfn_flags_t         out_flags
);
  localparam int N = RootBits;

  typedef struct packed {
    logic [MagBits-1:0] x, y, z;
    tfn_flags_t         f;
  } carry_t;

  logic [2*MagBits-1:0] qx_r, qy_r, qz_r;
  carry_t               c0_r;
  logic                 v0_r;
  logic [SumBits-1:0]   rem_r [N+1];
  logic [N-1:0]         res_r [N+1];
  carry_t               cs_r  [N+1];
  logic                 vs_r  [N+1];

  always_ff @(posedge clk) begin
    qx_r <= mx * mx;
    qy_r <= my * my;
    qz_r <= mz * mz;
    c0_r <= '{x: mx, y: my, z: mz, f: in_flags};
    rem_r[0] <= SumBits'(qx_r) + SumBits'(qy_r) + SumBits'(qz_r);
    res_r[0] <= '0;
    cs_r[0] <= c0_r;
  end

  for (genvar k = 0; k < N; k++) begin : g_root
    localparam int Sh = 2 * (N - 1 - k);
    logic [SumBits+1:0] trial;
    assign trial = ({2'b0, (SumBits'(res_r[k]) << 2)} + 66'(1)) << Sh;
    always_ff @(posedge clk) begin
      cs_r[k+1] <= cs_r[k];
      if ({2'b0, rem_r[k]} >= trial) begin
        rem_r[k+1] <= rem_r[k] - SumBits'(trial);
        res_r[k+1] <= {res_r[k][N-2:0], 1'b1};
      end else begin
        rem_r[k+1] <= rem_r[k];
        res_r[k+1] <= {res_r[k][N-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vs_r[k+1] <= 1'b0;
      else        vs_r[k+1] <= vs_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      vs_r[0] <= 1'b0;
    end else begin
      v0_r <= in_vld;
      vs_r[0] <= v0_r;
    end
  end

  assign out_vld   = vs_r[N];
  assign root      = res_r[N];
  assign ox        = cs_r[N].x;
  assign oy        = cs_r[N].y;
  assign oz        = cs_r[N].z;
  assign out_flags = cs_r[N].f;
endmodule

[hdl/tfn_div.sv]
// Pipelined restoring divider for one component, one quotient bit a stage.
module tfn_div
  import tfn_pkg::*;
#(
  parameter int FRAC = NormalFracBits
) (
  input  logic                clk,
  input  logic [MagBits-1:0]  num,
  input  logic [RootBits-1:0] den,
  output logic [FRAC:0]       quo
);
  localparam int Q  = FRAC + 1;
  localparam int NB = MagBits + FRAC + 1;
  localparam int RB = RootBits + 1;

  logic [NB-1:0]       n_r [Q+1];
  logic [RB-1:0]       r_r [Q+1];
  logic [RootBits-1:0] d_r [Q+1];
  logic [Q-1:0]        q_r [Q+1];

  always_ff @(posedge clk) begin
    n_r[0] <= (NB'(num) << FRAC) + NB'(den >> 1);
    d_r[0] <= den;
    r_r[0] <= '0;
    q_r[0] <= '0;
  end

  for (genvar k = 0; k < Q; k++) begin : g_bit
    logic [RB:0] t;
    if (k == 0) begin : g_first
      assign t = (RB+1)'(n_r[k] >> (Q - 1));
    end else begin : g_next
      assign t = {r_r[k], n_r[k][Q-1-k]};
    end
    always_ff @(posedge clk) begin
      n_r[k+1] <= n_r[k];
      d_r[k+1] <= d_r[k];
      if (t >= (RB+1)'(d_r[k])) begin
        r_r[k+1] <= RB'(t - (RB+1)'(d_r[k]));
        q_r[k+1] <= {q_r[k][Q-2:0], 1'b1};
      end else begin
        r_r[k+1] <= RB'(t);
        q_r[k+1] <= {q_r[k][Q-2:0], 1'b0};
      end
    end
  end

  assign quo = q_r[Q];
endmodule

[hdl/triangle_face_normal.sv]
// Top level: triangle unit face normal, fully pipelined.
// Usage:
//   Drive the nine signed Q8.8 vertex coordinates on in_* and pulse start.
//   busy is always low, so a word is taken every cycle start is high.
//   Each word yields exactly one result word: out_normal_x/y/z in signed
//   Q1.14 and out_degenerate, marked by out_strobe for one cycle.
//   A zero cross product gives (0, 1.0, 0) with out_degenerate set.
// Pipeline: edges, products and scaling; the sum of squares and the
//   bit-per-stage square root; the bit-per-stage dividers; the output
//   register.
// Throughput: one triangle per clock; every stage is a register stage.
// Reset: rst_n low clears all valid bits; no result appears from a word
//   taken before reset. Payload registers are not reset.
// The receiver cannot stall: results must be taken as they appear.
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_BITS       = CoordBits,
  parameter int NORMAL_FRAC_BITS = NormalFracBits
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_BITS-1:0]   in_first_x, in_first_y, in_first_z,
  input  logic signed [COORD_BITS-1:0]   in_second_x, in_second_y, in_second_z,
  input  logic signed [COORD_BITS-1:0]   in_third_x, in_third_y, in_third_z,
  output logic                           out_strobe,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_z,
  output logic                           out_degenerate
);
  localparam int OB = NORMAL_FRAC_BITS + 2;
  localparam int DL = NORMAL_FRAC_BITS + 2;

  logic               c_vld, s_vld;
  logic [MagBits-1:0] mx, my, mz, sx, sy, sz;
  logic [RootBits-1:0] root;
  tfn_flags_t         cf, sf;
  logic [NORMAL_FRAC_BITS:0] qx, qy, qz;
  logic               dv_r [DL];
  tfn_flags_t         df_r [DL];
  logic               stb_r, dg_r;
  logic [OB-1:0]      ox_r, oy_r, oz_r;

  assign busy = 1'b0;

  tfn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk, .rst_n, .in_vld(start && !busy),
    .p1x(in_first_x), .p1y(in_first_y), .p1z(in_first_z),
    .p2x(in_second_x), .p2y(in_second_y), .p2z(in_second_z),
    .p3x(in_third_x), .p3y(in_third_y), .p3z(in_third_z),
    .out_vld(c_vld), .mx, .my, .mz, .flags(cf)
  );

  tfn_sqrt u_sqrt (
    .clk, .rst_n, .in_vld(c_vld), .mx, .my, .mz, .in_flags(cf),
    .out_vld(s_vld), .ox(sx), .oy(sy), .oz(sz), .root, .out_flags(sf)
  );

  tfn_div #(.FRAC(NORMAL_FRAC_BITS)) u_div_x (.clk, .num(sx), .den(root), .quo(qx));
  tfn_div #(.FRAC(NORMAL_FRAC_BITS)) u_div_y (.clk, .num(sy), .den(root), .quo(qy));
  tfn_div #(.FRAC(NORMAL_FRAC_BITS)) u_div_z (.clk, .num(sz), .den(root), .quo(qz));

  always_ff @(posedge clk) begin
    df_r[0] <= sf;
    for (int i = 1; i < DL; i++) df_r[i] <= df_r[i-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) dv_r[i] <= 1'b0;
      stb_r <= 1'b0;
    end else begin
      dv_r[0] <= s_vld;
      for (int i = 1; i < DL; i++) dv_r[i] <= dv_r[i-1];
      stb_r <= dv_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    dg_r <= df_r[DL-1].degen;
    if (df_r[DL-1].degen) begin
      ox_r <= '0;
      oy_r <= OB'(1) << NORMAL_FRAC_BITS;
      oz_r <= '0;
    end else begin
      ox_r <= df_r[DL-1].neg_x ? OB'(-OB'(qx)) : OB'(qx);
      oy_r <= df_r[DL-1].neg_y ? OB'(-OB'(qy)) : OB'(qy);
      oz_r <= df_r[DL-1].neg_z ? OB'(-OB'(qz)) : OB'(qz);
    end
  end

  assign out_strobe     = stb_r;
  assign out_normal_x   = ox_r;
  assign out_normal_y   = oy_r;
  assign out_normal_z   = oz_r;
  assign out_degenerate = dg_r;

  a_deg_y : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_degenerate |-> out_normal_x == '0 && out_normal_z == '0)
    else $error("degenerate word with nonzero x or z");
  a_busy : assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(dv_r[DL-1]))
    else $error("strobe without a word in flight");
endmodule
